### sv/utf16_to_utf8_transcoder_assert.svh
// Assertion macros for the transcoder RTL.
// Depends on nothing; included by u16u8_back, which checks its own logic.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define U16U8_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define U16U8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/u16u8_pkg.sv
// Types, constants and the UTF-8 encoder function of the UTF-16 to UTF-8 transcoder.
// Depends on nothing; used by every module of the block.
package u16u8_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CNT_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [20:0] HIGH_FIRST = 21'h00D800;
	localparam logic [20:0] HIGH_LAST  = 21'h00DBFF;
	localparam logic [20:0] LOW_FIRST  = 21'h00DC00;
	localparam logic [20:0] LOW_LAST   = 21'h00DFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h010000;
	localparam logic [20:0] LIM1       = 21'h000080;
	localparam logic [20:0] LIM2       = 21'h000800;
	localparam logic [20:0] LIM3       = 21'h010000;
	localparam logic [5:0]  HIGH_TAG   = 6'b110110;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [20:0] code_unit;
		logic        last_unit;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        end_of_run;
		logic        string_done;
		logic        status;
		logic [15:0] byte_count;
	} result_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} utf8_t;

	// one accepted item's work for the back end
	typedef struct packed {
		logic [2:0][7:0] a_bytes;
		logic            a_en;
		logic [3:0][7:0] b_bytes;
		logic [2:0]      b_len;
		logic            stat_en;
		logic            status;
		logic [15:0]     count;
	} job_t;

	function automatic utf8_t encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < LIM1) begin
			r.bytes[0] = cp[7:0];
			r.len      = 3'd1;
		end else if (cp < LIM2) begin
			r.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
			r.bytes[1] = CONT | {2'b00, cp[5:0]};
			r.len      = 3'd2;
		end else if (cp < LIM3) begin
			r.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
			r.bytes[1] = CONT | {2'b00, cp[11:6]};
			r.bytes[2] = CONT | {2'b00, cp[5:0]};
			r.len      = 3'd3;
		end else begin
			r.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
			r.bytes[1] = CONT | {2'b00, cp[17:12]};
			r.bytes[2] = CONT | {2'b00, cp[11:6]};
			r.bytes[3] = CONT | {2'b00, cp[5:0]};
			r.len      = 3'd4;
		end
		return r;
	endfunction

	function automatic logic [3:0] job_results(input job_t j);
		return (j.a_en ? 4'd3 : 4'd0) + {1'b0, j.b_len} + {3'b000, j.stat_en};
	endfunction

endpackage

### sv/u16u8_front.sv
// Front end: capacity register, surrogate pairing, byte accounting and job building.
// Depends on u16u8_pkg; feeds u16u8_queue.
module u16u8_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                capacity_we,
	input  logic [15:0]         capacity_wdata,
	input  u16u8_pkg::item_t    item,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                q_full,
	output logic                push,
	output u16u8_pkg::job_t     job
);

	logic [15:0]                   cap_q;
	logic                          held_q;
	logic [9:0]                    bits_q;
	logic [u16u8_pkg::CNT_W-1:0]   bw_q;
	logic                          ov_q;

	logic [20:0]                   cu;
	logic                          is_high, is_low, pair, has_a, has_b, hold, count_only;
	logic [20:0]                   cp_a, cp_b;
	u16u8_pkg::utf8_t              enc_a, enc_b;
	logic [2:0]                    len_a, len_b;
	logic [u16u8_pkg::CNT_W:0]     sum_a, sum_b, cap_ext;
	logic                          fail_a, fail_b, emit_a, emit_b, ov_n, held_n, accept;
	logic [u16u8_pkg::CNT_W-1:0]   bw_n;

	always_comb begin
		cu      = item.code_unit;
		is_high = (cu >= u16u8_pkg::HIGH_FIRST) && (cu <= u16u8_pkg::HIGH_LAST);
		is_low  = (cu >= u16u8_pkg::LOW_FIRST) && (cu <= u16u8_pkg::LOW_LAST);
		pair    = held_q && is_low;
		has_a   = held_q && !is_low;
		hold    = !pair && is_high && !item.last_unit;
		has_b   = pair || !hold;

		cp_a  = {5'b00000, u16u8_pkg::HIGH_TAG, bits_q};
		cp_b  = pair ? (u16u8_pkg::SUPP_BASE + {1'b0, bits_q, cu[9:0]}) : cu;
		enc_a = u16u8_pkg::encode(cp_a);
		enc_b = u16u8_pkg::encode(cp_b);
		len_a = has_a ? 3'd3 : 3'd0;
		len_b = has_b ? enc_b.len : 3'd0;

		sum_a   = {1'b0, bw_q} + (u16u8_pkg::CNT_W+1)'(len_a);
		sum_b   = sum_a + (u16u8_pkg::CNT_W+1)'(len_b);
		cap_ext = (u16u8_pkg::CNT_W+1)'(cap_q);
		count_only = (cap_q == 16'd0);

		fail_a = !ov_q && !count_only && has_a && (sum_a > cap_ext);
		fail_b = !ov_q && !count_only && !fail_a && has_b && (sum_b > cap_ext);
		emit_a = !ov_q && !count_only && has_a && !fail_a;
		emit_b = !ov_q && !count_only && has_b && !fail_a && !fail_b;
		ov_n   = ov_q || fail_a || fail_b;
		held_n = hold && !ov_n;

		if (ov_q) begin
			bw_n = bw_q;
		end else if (count_only) begin
			bw_n = (sum_b > {1'b0, u16u8_pkg::COUNT_MAX}) ? u16u8_pkg::COUNT_MAX
			                                              : sum_b[u16u8_pkg::CNT_W-1:0];
		end else if (fail_a) begin
			bw_n = bw_q;
		end else if (fail_b) begin
			bw_n = sum_a[u16u8_pkg::CNT_W-1:0];
		end else begin
			bw_n = sum_b[u16u8_pkg::CNT_W-1:0];
		end

		job.a_bytes = enc_a.bytes[2:0];
		job.a_en    = emit_a;
		job.b_bytes = enc_b.bytes;
		job.b_len   = emit_b ? enc_b.len : 3'd0;
		job.stat_en = item.last_unit;
		job.status  = ov_n ? u16u8_pkg::STATUS_OVERFLOW : u16u8_pkg::STATUS_OK;
		job.count   = ov_n ? 16'd0 : bw_n[15:0];
	end

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign push       = accept && (emit_a || emit_b || item.last_unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= '0;
			held_q <= 1'b0;
			bits_q <= '0;
			bw_q   <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (capacity_we) begin
				cap_q <= capacity_wdata;
			end
			if (accept) begin
				if (item.last_unit) begin
					held_q <= 1'b0;
					bits_q <= '0;
					bw_q   <= '0;
					ov_q   <= 1'b0;
				end else begin
					held_q <= held_n;
					if (hold && !ov_n) begin
						bits_q <= cu[9:0];
					end
					bw_q <= bw_n;
					ov_q <= ov_n;
				end
			end
		end
	end

endmodule

### sv/u16u8_queue.sv
// Short job queue between the front and back ends.
// Depends on u16u8_pkg.
module u16u8_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u16u8_pkg::job_t  push_job,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output u16u8_pkg::job_t  head
);

	u16u8_pkg::job_t                mem_q [u16u8_pkg::QDEPTH];
	logic [u16u8_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [u16u8_pkg::QCNT_W-1:0]   cnt_q;

	function automatic logic [u16u8_pkg::QPTR_W-1:0] next_ptr(
		input logic [u16u8_pkg::QPTR_W-1:0] p);
		return (p == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1)) ? '0
		                                                        : p + 1'b1;
	endfunction

	assign full       = (cnt_q == u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/u16u8_back.sv
// Back end: walks one job's bytes, and its status if it has one, into the registered result port.
// Depends on u16u8_pkg and utf16_to_utf8_transcoder_assert.svh.
`include "utf16_to_utf8_transcoder_assert.svh"

module u16u8_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  u16u8_pkg::job_t     head,
	output logic                pop,
	output u16u8_pkg::result_t  result,
	output logic                result_valid,
	input  logic                result_ready
);

	logic [2:0]          idx_q;
	logic                res_valid_q;
	u16u8_pkg::result_t  res_q;

	logic [3:0]          total;
	logic [2:0]          a_cnt, j;
	logic                in_a, eor, load;
	u16u8_pkg::result_t  nxt;

	always_comb begin
		total = u16u8_pkg::job_results(head);
		a_cnt = head.a_en ? 3'd3 : 3'd0;
		in_a  = head.a_en && (idx_q < 3'd3);
		j     = idx_q - a_cnt;
		eor   = ({1'b0, idx_q} == (total - 4'd1));

		nxt            = '0;
		nxt.end_of_run = eor;
		if (in_a) begin
			nxt.out_byte   = head.a_bytes[idx_q[1:0]];
			nxt.byte_valid = 1'b1;
		end else if (j < head.b_len) begin
			nxt.out_byte   = head.b_bytes[j[1:0]];
			nxt.byte_valid = 1'b1;
		end else begin
			nxt.string_done = 1'b1;
			nxt.status      = head.status;
			nxt.byte_count  = head.count;
		end
	end

	assign load         = head_valid && (!res_valid_q || result_ready);
	assign pop          = load && eor;
	assign result       = res_q;
	assign result_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	`U16U8_ASSERT_IMPLY(a_idx_in_job, clk, arst_n, head_valid, {1'b0, idx_q} < total, "index past end of job")
	`U16U8_ASSERT_IMPLY(a_idx_idle_zero, clk, arst_n, !head_valid, idx_q == 3'd0, "index not cleared with empty queue")
	`U16U8_ASSERT_IMPLY(a_done_shape, clk, arst_n, res_valid_q && res_q.string_done, res_q.end_of_run && !res_q.byte_valid, "status transaction malformed")
	`U16U8_ASSERT_IMPLY(a_ovf_count, clk, arst_n, res_valid_q && res_q.status == u16u8_pkg::STATUS_OVERFLOW, res_q.byte_count == 16'd0, "overflow with nonzero count")
	`U16U8_ASSERT_NEXT(a_idx_step, clk, arst_n, load && !eor, idx_q == 3'($past(idx_q) + 3'd1), "index did not advance")

endmodule

### sv/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Takes one code unit per item transaction and returns UTF-8 bytes, then one status
// transaction after the unit flagged last_unit. The front end accepts an item every
// cycle while its four-entry job queue has room; the back end drains one result per
// cycle into a registered output unless result_ready holds it back, so an item's
// results leave one by one: none for a held high surrogate, up to eight in all.
// The first result of an item is registered in the job queue and then in the output
// register, and waits while earlier jobs or results are pending. Write capacity only while
// no string is in flight; zero selects count-only mode.
module utf16_to_utf8_transcoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                capacity_we,
	input  logic [15:0]         capacity_wdata,
	input  u16u8_pkg::item_t    item,
	input  logic                item_valid,
	output logic                item_ready,
	output u16u8_pkg::result_t  result,
	output logic                result_valid,
	input  logic                result_ready
);

	logic             q_full, push, pop, head_valid;
	u16u8_pkg::job_t  push_job, head;

	u16u8_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.item           (item),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.q_full         (q_full),
		.push           (push),
		.job            (push_job)
	);

	u16u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	u16u8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
